/* rtl/csc_pkg.sv */
package csc_pkg;

  localparam int FIELD_W = 13;
  localparam int ACT_W   = 3;
  localparam int TDATA_W = 56;

  // fixed point: 12 fraction bits on components, 4 on hue
  localparam logic [FIELD_W-1:0] ONE     = 13'd4096;
  localparam int                 HUE60_I = 960;
  localparam logic [FIELD_W-1:0] HUE60   = 13'd960;
  localparam logic [FIELD_W-1:0] HUE360  = 13'd5760;
  localparam logic [21:0]        DEN60   = 22'd3932160;       // ONE * HUE60
  localparam logic [25:0]        FULL2   = 26'd33554432;      // 2 * ONE * ONE

  // divider lanes
  localparam int NUM_W = 37;
  localparam int DEN_W = 34;
  localparam int QW    = 14;
  localparam int LANES = 4;
  localparam logic [DEN_W-1:0] DEN4 = 34'd16106127360;        // ONE * ONE * HUE60

  localparam logic [ACT_W-1:0] ACT_RGB2HSV = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HSV2RGB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HSV2HSL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HSL2HSV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_HSL2RGB = 3'd4;

endpackage

/* rtl/color_space_converter.sv */
// channel  | ports                          | contents (lowest bit first)
// in       | in_tvalid in_tready in_tdata   | hue_in, hue_none_in, first_in, second_in,
//          | in_tuser                       | third_in; tuser: action
// out      | out_tvalid out_tready out_tdata| hue_out, hue_none_out, first_out,
//          |                                | second_out, third_out
//
// one request per clock when the output side keeps up
// 6 setup stages (saturate, sort, two product levels, operand select, divider load)
// then 14 restoring divider steps on four parallel lanes, then the output register
// each stage holds its data while the stage after it is full, bubbles are squeezed out
// reset clears the valid bits only
module color_space_converter
  import csc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // hue_in, hue_none_in, first_in, second_in, third_in
  input  logic [ACT_W-1:0]   in_tuser,   // action
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // hue_out, hue_none_out, first_out, second_out, third_out
);

  localparam int NST = 7 + QW;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               none;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] c1;
    logic [FIELD_W-1:0] c2;
    logic [FIELD_W-1:0] c3;
  } s1_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               none;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] c1;
    logic [FIELD_W-1:0] c2;
    logic [FIELD_W-1:0] c3;
    logic [FIELD_W-1:0] mx;
    logic [FIELD_W-1:0] d;
    logic               mxr;
    logic               mxg;
    logic [FIELD_W-1:0] m3;
    logic [2:0]         i;
    logic [9:0]         f;
    logic [10:0]        fm;
  } s2_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               none;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] c3;
    logic               gray;
    logic [2:0]         i;
    logic [9:0]         f;
    logic [10:0]        fm;
    logic [FIELD_W-1:0] d;
    logic [FIELD_W-1:0] mx;
    logic [22:0]        c2f;
    logic [23:0]        c2fm;
    logic [25:0]        c3omc2;
    logic [25:0]        l2;
    logic [25:0]        c3c2;
    logic [24:0]        mm;
    logic [24:0]        hnum;
  } s3_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               none;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] c3;
    logic               gray;
    logic [2:0]         i;
    logic [FIELD_W-1:0] d;
    logic [FIELD_W-1:0] mx;
    logic [25:0]        c3omc2;
    logic [25:0]        l2;
    logic [25:0]        c3c2;
    logic [24:0]        mm;
    logic [24:0]        hnum;
    logic [34:0]        qn;
    logic [34:0]        tn;
    logic [34:0]        mmf;
    logic [34:0]        mmfm;
    logic [34:0]        base;
    logic [34:0]        mm1920;
    logic [25:0]        vv;
    logic               z2;
    logic [25:0]        dn2;
  } s4_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic               hn;
    logic [FIELD_W-1:0] hue;
    logic [FIELD_W-1:0] keep;
    logic               gray;
    logic [2:0]         i;
  } meta_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } lop_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    low;
    logic [QW-1:0]    q;
    logic [DEN_W-1:0] den;
    logic             ovf;
  } dstep_t;

  typedef struct packed {
    logic [FIELD_W-1:0] hue;
    logic               hn;
    logic [FIELD_W-1:0] o1;
    logic [FIELD_W-1:0] o2;
    logic [FIELD_W-1:0] o3;
  } res_t;

  function automatic logic [3*FIELD_W-1:0] sector_f(input logic [2:0] i,
                                                   input logic [FIELD_W-1:0] hi,
                                                   input logic [FIELD_W-1:0] rise,
                                                   input logic [FIELD_W-1:0] fall,
                                                   input logic [FIELD_W-1:0] lo);
    logic [3*FIELD_W-1:0] rgb;
    case (i)
      3'd0:    rgb = {hi, rise, lo};
      3'd1:    rgb = {fall, hi, lo};
      3'd2:    rgb = {lo, hi, rise};
      3'd3:    rgb = {lo, fall, hi};
      3'd4:    rgb = {rise, lo, hi};
      default: rgb = {hi, lo, fall};
    endcase
    return rgb;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_f(input dstep_t s);
    logic [FIELD_W-1:0] v;
    if (s.ovf || s.q > QW'(ONE)) v = ONE;
    else v = s.q[FIELD_W-1:0];
    return v;
  endfunction

  logic [NST-1:0] vld_r;
  logic [NST-1:0] mv;

  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  s3_t    s3_r, s3_nxt;
  s4_t    s4_r, s4_nxt;
  lop_t   lop_r [LANES];
  lop_t   lop_nxt [LANES];
  meta_t  meta_r [QW+2];
  meta_t  meta_nxt;
  dstep_t dv_r [QW+1][LANES];
  dstep_t dv_nxt [QW+1][LANES];
  res_t   out_r, out_nxt;

  // stage k loads when it is empty or its content moves on
  always_comb begin
    mv[NST-1] = !vld_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      mv[k] = !vld_r[k] || mv[k+1];
    end
  end

  assign in_tready  = mv[0];
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {3'b000, out_r.o3, out_r.o2, out_r.o1, out_r.hn, out_r.hue};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (mv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (mv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: saturate components, wrap hue
  always_comb begin
    logic [FIELD_W-1:0] h;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
    h = in_tdata[12:0];
    a = in_tdata[26:14];
    b = in_tdata[39:27];
    c = in_tdata[52:40];
    s1_nxt.act  = in_tuser;
    s1_nxt.none = in_tdata[13];
    s1_nxt.hue  = (h >= HUE360) ? h - HUE360 : h;
    s1_nxt.c1   = (a > ONE) ? ONE : a;
    s1_nxt.c2   = (b > ONE) ? ONE : b;
    s1_nxt.c3   = (c > ONE) ? ONE : c;
  end

  // stage 2: max, min, hue sector
  always_comb begin
    logic [FIELD_W-1:0] mx;
    logic [FIELD_W-1:0] mn;
    logic [FIELD_W-1:0] omc3;
    logic [2:0]         i;
    logic [FIELD_W-1:0] fr;
    mx = s1_r.c1;
    mn = s1_r.c1;
    if (s1_r.c2 > mx) mx = s1_r.c2;
    if (s1_r.c3 > mx) mx = s1_r.c3;
    if (s1_r.c2 < mn) mn = s1_r.c2;
    if (s1_r.c3 < mn) mn = s1_r.c3;
    omc3 = ONE - s1_r.c3;
    i = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (s1_r.hue >= FIELD_W'(k * HUE60_I)) i = 3'(k);
    end
    fr = s1_r.hue - FIELD_W'(i) * HUE60;
    s2_nxt.act  = s1_r.act;
    s2_nxt.none = s1_r.none;
    s2_nxt.hue  = s1_r.hue;
    s2_nxt.c1   = s1_r.c1;
    s2_nxt.c2   = s1_r.c2;
    s2_nxt.c3   = s1_r.c3;
    s2_nxt.mx   = mx;
    s2_nxt.d    = mx - mn;
    s2_nxt.mxr  = (mx == s1_r.c1);
    s2_nxt.mxg  = (mx != s1_r.c1) && (mx == s1_r.c2);
    s2_nxt.m3   = (s1_r.c3 < omc3) ? s1_r.c3 : omc3;
    s2_nxt.i    = i;
    s2_nxt.f    = fr[9:0];
    s2_nxt.fm   = 11'(HUE60_I) - {1'b0, fr[9:0]};
  end

  // stage 3: first level of products
  always_comb begin
    logic [24:0] hn;
    if (s2_r.mxr) begin
      if (s2_r.c2 >= s2_r.c3) hn = 25'(HUE60) * 25'(s2_r.c2 - s2_r.c3);
      else hn = 25'(HUE360) * 25'(s2_r.d) - 25'(HUE60) * 25'(s2_r.c3 - s2_r.c2);
    end else if (s2_r.mxg) begin
      hn = 25'(HUE60) * (25'(s2_r.c3) + (25'(s2_r.d) << 1) - 25'(s2_r.c1));
    end else begin
      hn = 25'(HUE60) * (25'(s2_r.c1) + (25'(s2_r.d) << 2) - 25'(s2_r.c2));
    end
    s3_nxt.act    = s2_r.act;
    s3_nxt.none   = s2_r.none;
    s3_nxt.hue    = s2_r.hue;
    s3_nxt.c3     = s2_r.c3;
    s3_nxt.gray   = (s2_r.c2 == '0) || s2_r.none;
    s3_nxt.i      = s2_r.i;
    s3_nxt.f      = s2_r.f;
    s3_nxt.fm     = s2_r.fm;
    s3_nxt.d      = s2_r.d;
    s3_nxt.mx     = s2_r.mx;
    s3_nxt.c2f    = 23'(s2_r.c2) * 23'(s2_r.f);
    s3_nxt.c2fm   = 24'(s2_r.c2) * 24'(s2_r.fm);
    s3_nxt.c3omc2 = 26'(s2_r.c3) * 26'(ONE - s2_r.c2);
    s3_nxt.l2     = 26'(s2_r.c3) * (26'(ONE) * 26'd2 - 26'(s2_r.c2));
    s3_nxt.c3c2   = 26'(s2_r.c3) * 26'(s2_r.c2);
    s3_nxt.mm     = 25'(s2_r.m3) * 25'(s2_r.c2);
    s3_nxt.hnum   = hn;
  end

  // stage 4: second level of products and sums
  always_comb begin
    logic [25:0] rest;
    rest = FULL2 - s3_r.l2;
    s4_nxt.act    = s3_r.act;
    s4_nxt.none   = s3_r.none;
    s4_nxt.hue    = s3_r.hue;
    s4_nxt.c3     = s3_r.c3;
    s4_nxt.gray   = s3_r.gray;
    s4_nxt.i      = s3_r.i;
    s4_nxt.d      = s3_r.d;
    s4_nxt.mx     = s3_r.mx;
    s4_nxt.c3omc2 = s3_r.c3omc2;
    s4_nxt.l2     = s3_r.l2;
    s4_nxt.c3c2   = s3_r.c3c2;
    s4_nxt.mm     = s3_r.mm;
    s4_nxt.hnum   = s3_r.hnum;
    s4_nxt.qn     = 35'(s3_r.c3) * 35'(DEN60 - s3_r.c2f[21:0]);
    s4_nxt.tn     = 35'(s3_r.c3) * 35'(DEN60 - s3_r.c2fm[21:0]);
    s4_nxt.mmf    = 35'(s3_r.mm) * 35'(s3_r.f);
    s4_nxt.mmfm   = 35'(s3_r.mm) * 35'(s3_r.fm);
    s4_nxt.base   = 35'(s3_r.c3) * 35'(DEN60) - 35'(s3_r.mm) * 35'(HUE60);
    s4_nxt.mm1920 = 35'(s3_r.mm) * 35'(HUE60) * 35'd2;
    s4_nxt.vv     = (26'(s3_r.c3) << 12) + 26'(s3_r.mm);
    s4_nxt.z2     = (s3_r.l2 == '0) || (s3_r.l2 >= FULL2);
    s4_nxt.dn2    = (s3_r.l2 < rest) ? s3_r.l2 : rest;
  end

  // stage 5: pick dividend and divisor per lane, add half divisor for rounding
  always_comb begin
    lop_t op [LANES];
    for (int l = 0; l < LANES; l++) begin
      op[l].num = '0;
      op[l].den = DEN_W'(1);
    end
    meta_nxt.act  = s4_r.act;
    meta_nxt.hn   = 1'b0;
    meta_nxt.hue  = '0;
    meta_nxt.keep = s4_r.c3;
    meta_nxt.gray = s4_r.gray;
    meta_nxt.i    = s4_r.i;
    unique case (s4_r.act)
      ACT_RGB2HSV: begin
        meta_nxt.hn   = (s4_r.d == '0);
        meta_nxt.keep = s4_r.mx;
        if (s4_r.mx != '0) begin
          op[0].num = NUM_W'(s4_r.d) << 12;
          op[0].den = DEN_W'(s4_r.mx);
        end
        if (s4_r.d != '0) begin
          op[1].num = NUM_W'(s4_r.hnum);
          op[1].den = DEN_W'(s4_r.d);
        end
      end
      ACT_HSV2RGB: begin
        op[0].num = NUM_W'(s4_r.c3omc2);
        op[0].den = DEN_W'(ONE);
        op[1].num = NUM_W'(s4_r.qn);
        op[1].den = DEN_W'(DEN60);
        op[2].num = NUM_W'(s4_r.tn);
        op[2].den = DEN_W'(DEN60);
      end
      ACT_HSV2HSL: begin
        meta_nxt.hn  = s4_r.none;
        meta_nxt.hue = s4_r.none ? '0 : s4_r.hue;
        op[0].num = NUM_W'(s4_r.l2);
        op[0].den = DEN_W'(ONE) << 1;
        if (!s4_r.z2) begin
          op[1].num = NUM_W'(s4_r.c3c2) << 12;
          op[1].den = DEN_W'(s4_r.dn2);
        end
      end
      ACT_HSL2HSV: begin
        meta_nxt.hn  = s4_r.none;
        meta_nxt.hue = s4_r.none ? '0 : s4_r.hue;
        op[0].num = NUM_W'(s4_r.vv);
        op[0].den = DEN_W'(ONE);
        if (s4_r.vv != '0) begin
          op[1].num = NUM_W'(s4_r.mm) << 13;
          op[1].den = DEN_W'(s4_r.vv);
        end
      end
      ACT_HSL2RGB: begin
        op[0].num = NUM_W'(s4_r.base) + NUM_W'(s4_r.mm1920);
        op[1].num = NUM_W'(s4_r.base) + (NUM_W'(s4_r.mmf) << 1);
        op[2].num = NUM_W'(s4_r.base) + (NUM_W'(s4_r.mmfm) << 1);
        op[3].num = NUM_W'(s4_r.base);
        for (int l = 0; l < LANES; l++) op[l].den = DEN4;
      end
      default: begin
      end
    endcase
    for (int l = 0; l < LANES; l++) begin
      lop_nxt[l].num = op[l].num + NUM_W'(op[l].den >> 1);
      lop_nxt[l].den = op[l].den;
    end
  end

  // stage 6 loads the dividers, then one quotient bit per stage
  always_comb begin
    logic [DEN_W:0] t;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      dv_nxt[0][l].rem = DEN_W'(lop_r[l].num[NUM_W-1:QW]);
      dv_nxt[0][l].low = lop_r[l].num[QW-1:0];
      dv_nxt[0][l].q   = '0;
      dv_nxt[0][l].den = lop_r[l].den;
      // quotient would not fit in QW bits
      dv_nxt[0][l].ovf = DEN_W'(lop_r[l].num[NUM_W-1:QW]) >= lop_r[l].den;
    end
    for (int j = 1; j <= QW; j++) begin
      for (int l = 0; l < LANES; l++) begin
        t  = {dv_r[j-1][l].rem, dv_r[j-1][l].low[QW-1]};
        ge = t >= {1'b0, dv_r[j-1][l].den};
        dv_nxt[j][l].rem = ge ? DEN_W'(t - {1'b0, dv_r[j-1][l].den}) : t[DEN_W-1:0];
        dv_nxt[j][l].low = dv_r[j-1][l].low << 1;
        dv_nxt[j][l].q   = {dv_r[j-1][l].q[QW-2:0], ge};
        dv_nxt[j][l].den = dv_r[j-1][l].den;
        dv_nxt[j][l].ovf = dv_r[j-1][l].ovf;
      end
    end
  end

  // output assembly
  always_comb begin
    meta_t              m;
    logic [QW-1:0]      hq;
    logic [FIELD_W-1:0] cl [LANES];
    logic [3*FIELD_W-1:0] rgb;
    m  = meta_r[QW+1];
    hq = dv_r[QW][1].q;
    for (int l = 0; l < LANES; l++) cl[l] = clamp_f(dv_r[QW][l]);
    out_nxt = '0;
    rgb = '0;
    unique case (m.act) inside
      ACT_RGB2HSV: begin
        out_nxt.hue = (hq >= QW'(HUE360)) ? FIELD_W'(hq - QW'(HUE360)) : hq[FIELD_W-1:0];
        out_nxt.hn  = m.hn;
        out_nxt.o2  = cl[0];
        out_nxt.o3  = m.keep;
      end
      ACT_HSV2RGB: begin
        rgb = m.gray ? {m.keep, m.keep, m.keep} : sector_f(m.i, m.keep, cl[2], cl[1], cl[0]);
        {out_nxt.o1, out_nxt.o2, out_nxt.o3} = rgb;
      end
      ACT_HSV2HSL, ACT_HSL2HSV: begin
        out_nxt.hue = m.hue;
        out_nxt.hn  = m.hn;
        out_nxt.o2  = cl[1];
        out_nxt.o3  = cl[0];
      end
      ACT_HSL2RGB: begin
        rgb = m.gray ? {m.keep, m.keep, m.keep} : sector_f(m.i, cl[0], cl[1], cl[2], cl[3]);
        {out_nxt.o1, out_nxt.o2, out_nxt.o3} = rgb;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mv[0]) s1_r <= s1_nxt;
    if (mv[1]) s2_r <= s2_nxt;
    if (mv[2]) s3_r <= s3_nxt;
    if (mv[3]) s4_r <= s4_nxt;
    if (mv[4]) begin
      lop_r     <= lop_nxt;
      meta_r[0] <= meta_nxt;
    end
    for (int j = 0; j <= QW; j++) begin
      if (mv[5+j]) begin
        dv_r[j]     <= dv_nxt[j];
        meta_r[j+1] <= meta_r[j];
      end
    end
    if (mv[NST-1]) out_r <= out_nxt;
  end

endmodule

/* rtl/csc_checker.sv */
module csc_checker
  import csc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [TDATA_W-1:0] in_tdata,
  input logic [ACT_W-1:0]   in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // held request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request dropped or changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:0] < HUE360)
    else $error("hue out of range");

  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[12:0] == '0)
    else $error("achromatic result carries a hue");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:14] <= ONE && out_tdata[39:27] <= ONE
                   && out_tdata[52:40] <= ONE && out_tdata[55:53] == '0)
    else $error("component above one or pad bits set");

endmodule

bind color_space_converter csc_checker u_csc_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import csc_pkg::*;

  typedef bit [63:0] u64;

  typedef struct {
    bit [12:0] hue;
    bit        none;
    bit [12:0] first;
    bit [12:0] second;
    bit [12:0] third;
  } colour_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic [ACT_W-1:0]   in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  color_space_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic u64 sat_one(u64 v);
    return (v > 64'd4096) ? 64'd4096 : v;
  endfunction

  function automatic u64 rnd_div(u64 n, u64 d);
    return (n + d / 2) / d;
  endfunction

  function automatic u64 lesser(u64 a, u64 b);
    return (a < b) ? a : b;
  endfunction

  // sector order: hi, rising, falling, lo
  function automatic void hue_sector(u64 i, u64 hi, u64 rise, u64 fall, u64 lo,
                                     output u64 r, output u64 g, output u64 b);
    case (i)
      0: begin r = hi; g = rise; b = lo; end
      1: begin r = fall; g = hi; b = lo; end
      2: begin r = lo; g = hi; b = rise; end
      3: begin r = lo; g = fall; b = hi; end
      4: begin r = rise; g = lo; b = hi; end
      default: begin r = hi; g = lo; b = fall; end
    endcase
  endfunction

  function automatic colour_t convert_colour(bit [2:0] act, colour_t c);
    u64 one, h60, h360, hue, nn, c1, c2, c3, ho, hn, o1, o2, o3;
    u64 mx, mn, d, num, i, f, den, p, q, t, l2, full, m, vv, mm, base, hi, ri, fa, lo;
    colour_t r;
    one = 4096; h60 = 960; h360 = 5760;
    hue = u64'(c.hue) % h360;
    nn = u64'(c.none);
    c1 = sat_one(u64'(c.first)); c2 = sat_one(u64'(c.second)); c3 = sat_one(u64'(c.third));
    ho = 0; hn = 0; o1 = 0; o2 = 0; o3 = 0;
    case (act)
      ACT_RGB2HSV: begin
        mx = c1; mn = c1;
        if (c2 > mx) mx = c2;
        if (c3 > mx) mx = c3;
        if (c2 < mn) mn = c2;
        if (c3 < mn) mn = c3;
        d = mx - mn;
        o3 = mx;
        o2 = (mx == 0) ? 0 : sat_one(rnd_div(d * one, mx));
        if (d == 0) hn = 1;
        else begin
          if (mx == c1) num = (c2 >= c3) ? h60 * (c2 - c3) : h360 * d - h60 * (c3 - c2);
          else if (mx == c2) num = h60 * (c3 + 2 * d - c1);
          else num = h60 * (c1 + 4 * d - c2);
          ho = rnd_div(num, d);
          if (ho >= h360) ho -= h360;
        end
      end
      ACT_HSV2RGB: begin
        if (c2 == 0 || nn != 0) begin
          o1 = c3; o2 = c3; o3 = c3;
        end else begin
          i = hue / h60; f = hue % h60; den = one * h60;
          p = rnd_div(c3 * (one - c2), one);
          q = rnd_div(c3 * (den - c2 * f), den);
          t = rnd_div(c3 * (den - c2 * (h60 - f)), den);
          hue_sector(i, c3, t, q, p, o1, o2, o3);
        end
      end
      ACT_HSV2HSL: begin
        l2 = c3 * (2 * one - c2);
        full = 2 * one * one;
        ho = nn ? 0 : hue; hn = nn;
        o3 = sat_one(rnd_div(l2, 2 * one));
        if (l2 == 0 || l2 >= full) o2 = 0;
        else o2 = sat_one(rnd_div(c3 * c2 * one, lesser(l2, full - l2)));
      end
      ACT_HSL2HSV: begin
        m = lesser(c3, one - c3);
        vv = c3 * one + c2 * m;
        ho = nn ? 0 : hue; hn = nn;
        o3 = sat_one(rnd_div(vv, one));
        o2 = (vv == 0) ? 0 : sat_one(rnd_div(2 * c2 * m * one, vv));
      end
      ACT_HSL2RGB: begin
        if (c2 == 0 || nn != 0) begin
          o1 = c3; o2 = c3; o3 = c3;
        end else begin
          i = hue / h60; f = hue % h60; den = one * one * h60;
          mm = lesser(c3, one - c3) * c2;
          base = c3 * one * h60 - mm * h60;
          hi = sat_one(rnd_div(base + 2 * mm * h60, den));
          ri = sat_one(rnd_div(base + 2 * mm * f, den));
          fa = sat_one(rnd_div(base + 2 * mm * (h60 - f), den));
          lo = sat_one(rnd_div(base, den));
          hue_sector(i, hi, ri, fa, lo, o1, o2, o3);
        end
      end
      default: ;
    endcase
    r.hue = ho[12:0]; r.none = hn[0]; r.first = o1[12:0]; r.second = o2[12:0];
    r.third = o3[12:0];
    return r;
  endfunction

  class colour_board;
    colour_t pending[$];

    function void note_request(bit [2:0] act, colour_t c);
      pending.push_back(convert_colour(act, c));
    endfunction

    task check_result(colour_t got);
      colour_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.hue != e.hue) report($sformatf("hue %0d, want %0d", got.hue, e.hue));
      if (got.none != e.none) report($sformatf("hue_none %0d, want %0d", got.none, e.none));
      if (got.first != e.first) report($sformatf("first %0d, want %0d", got.first, e.first));
      if (got.second != e.second)
        report($sformatf("second %0d, want %0d", got.second, e.second));
      if (got.third != e.third) report($sformatf("third %0d, want %0d", got.third, e.third));
    endtask
  endclass

  colour_board board = new();

  // receiver: check, stall at random, watchdog
  always @(posedge clk) begin
    colour_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.hue = out_tdata[12:0]; got.none = out_tdata[13]; got.first = out_tdata[26:14];
        got.second = out_tdata[39:27]; got.third = out_tdata[52:40];
        board.check_result(got);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_colour(bit [2:0] act, bit [12:0] h, bit nn, bit [12:0] a, bit [12:0] b,
                             bit [12:0] c);
    colour_t col;
    col.hue = h; col.none = nn; col.first = a; col.second = b; col.third = c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b0, c, b, a, nn, h};
    do @(posedge clk); while (!in_tready);
    board.note_request(act, col);
  endtask

  function automatic bit [12:0] pick_comp();
    case ($urandom_range(7))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic send_random(int n);
    bit [2:0] act;
    bit [12:0] h, a, b, c;
    repeat (n) begin
      act = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      h = ($urandom_range(7) == 0) ? 13'($urandom_range(5760, 8191)) :
          13'($urandom_range(0, 5759));
      a = pick_comp(); b = pick_comp(); c = pick_comp();
      // provoke ties between channels now and then
      if ($urandom_range(7) == 0) b = a;
      if ($urandom_range(9) == 0) c = b;
      send_colour(act, h, ($urandom_range(3) == 0), a, b, c);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0; rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, gray, ties, wrap, unused actions
    send_colour(ACT_RGB2HSV, 0, 0, 0, 0, 0);
    send_colour(ACT_RGB2HSV, 0, 0, 4096, 4096, 4096);
    send_colour(ACT_RGB2HSV, 0, 0, 4096, 4096, 0);
    send_colour(ACT_RGB2HSV, 0, 0, 0, 4096, 4096);
    send_colour(ACT_RGB2HSV, 0, 0, 4096, 0, 1);
    send_colour(ACT_RGB2HSV, 0, 0, 8191, 100, 8191);
    send_colour(ACT_HSV2RGB, 5759, 0, 0, 4096, 4096);
    send_colour(ACT_HSV2RGB, 8191, 0, 0, 8191, 2000);
    send_colour(ACT_HSV2RGB, 1000, 1, 0, 4096, 3000);
    send_colour(ACT_HSV2RGB, 1000, 0, 0, 0, 3000);
    send_colour(ACT_HSV2HSL, 6000, 0, 0, 4096, 4096);
    send_colour(ACT_HSV2HSL, 300, 0, 0, 0, 4096);
    send_colour(ACT_HSV2HSL, 300, 1, 0, 2048, 0);
    send_colour(ACT_HSL2HSV, 4000, 0, 0, 4096, 0);
    send_colour(ACT_HSL2HSV, 4000, 0, 0, 4096, 2048);
    send_colour(ACT_HSL2HSV, 5760, 1, 0, 8191, 4096);
    send_colour(ACT_HSL2RGB, 2880, 0, 0, 4096, 2048);
    send_colour(ACT_HSL2RGB, 959, 0, 0, 4096, 4096);
    send_colour(ACT_HSL2RGB, 960, 1, 0, 4096, 1000);
    send_colour(3'd5, 8191, 1, 8191, 8191, 8191);
    send_colour(3'd6, 100, 0, 100, 100, 100);
    send_colour(3'd7, 0, 0, 0, 0, 0);

    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(100);
    drain();
    send_idle_pct = 49; recv_stall_pct = 0;  send_random(100);
    send_idle_pct = 0;  recv_stall_pct = 49; send_random(100);
    send_idle_pct = 14; recv_stall_pct = 14; send_random(100);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
